### hdl/mfhp_pkg.sv
// Package for the mesh frame header parser: header layout, status codes,
// register indexes and the result word layout.
// No dependencies.
package mfhp_pkg;

  localparam int HEADER_BYTES = 20;
  localparam int POS_W        = 9;
  localparam int POS_MAX      = 511;
  localparam int LEN_W        = POS_W + 1;

  localparam int POS_MAGIC     = 0;
  localparam int POS_VERSION   = 1;
  localparam int POS_TYPE      = 2;
  localparam int POS_SRC_FIRST = 3;
  localparam int POS_SRC_LAST  = 6;
  localparam int POS_DST_FIRST = 7;
  localparam int POS_DST_LAST  = 10;
  localparam int POS_NXT_FIRST = 11;
  localparam int POS_NXT_LAST  = 14;
  localparam int POS_HOPS      = 15;
  localparam int POS_MAX_HOPS  = 16;
  localparam int POS_SEQ_FIRST = 17;
  localparam int POS_SEQ_LAST  = 18;
  localparam int POS_LENGTH    = 19;

  localparam logic [7:0] TYPE_MIN = 8'h01;
  localparam logic [7:0] TYPE_MAX = 8'h05;

  localparam int OUT_FIFO_DEPTH = 4;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_MAGIC   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_VERSION = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOP_LIMIT        = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LIMIT    = 2'd3;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_SMALL   = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_BAD_TYPE    = 3'd4,
    ST_TOO_LARGE   = 3'd5
  } status_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Result word, padded to 160 bits; payload_byte sits in the lowest bits.
  typedef struct packed {
    logic [4:0]  pad;
    logic [7:0]  payload_length;
    logic [15:0] sequence_number;
    logic [7:0]  max_hops;
    logic [7:0]  hop_count;
    logic [31:0] next_hop_id;
    logic [31:0] destination_id;
    logic [31:0] source_id;
    logic [7:0]  packet_type;
    status_t     status;
    logic [7:0]  payload_byte;
  } result_word_t;

  localparam int RESULT_W = $bits(result_word_t);

  typedef struct packed {
    logic         result_kind;
    result_word_t word;
  } result_entry_t;

endpackage

### hdl/mesh_frame_header_parser_core.sv
// Top level of the mesh frame header parser: header capture, payload
// forwarding, end-of-frame summary and the output word queue.
// Depends on mfhp_pkg.
//
// Each result word is written into the output queue as its byte is accepted.
// Throughput: one byte per cycle while the queue has room for two words; a last
// byte that also forwards payload makes two words, which the output queue drains
// at one word per cycle while out_tready is high. Reset (rst_n low, synchronous)
// clears the frame state and the queue and restores the register defaults:
// magic 0, version 1, hop limit 15, payload limit 200.
module mesh_frame_header_parser_core #(
  parameter int FIFO_DEPTH = mfhp_pkg::OUT_FIFO_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // data_byte[7:0]
  input  logic                              in_tlast,   // frame_end
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // payload_byte[7:0], status[10:8], packet_type[18:11], source_id[50:19],
  // destination_id[82:51], next_hop_id[114:83], hop_count[122:115],
  // max_hops[130:123], sequence_number[146:131], payload_length[154:147],
  // zero[159:155]
  output logic [mfhp_pkg::RESULT_W-1:0]    out_tdata,
  output logic                              out_tuser,  // result_kind
  input  logic                              cfg_we,
  input  logic [mfhp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mfhp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mfhp_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_ACCEPT = CNT_W'(FIFO_DEPTH - 2);

  logic [7:0] expected_magic_r, expected_version_r, hop_limit_r, payload_limit_r;

  logic [POS_W-1:0] pos_r;
  logic [7:0]       magic_r, version_r, type_r;
  logic [31:0]      src_r, dst_r, next_hop_r;
  logic [7:0]       hops_taken_r, hops_allowed_r, len_r;
  logic [15:0]      seq_r;

  logic [7:0]       magic_nxt, version_nxt, type_nxt;
  logic [31:0]      src_nxt, dst_nxt, next_hop_nxt;
  logic [7:0]       hops_taken_nxt, hops_allowed_nxt, len_nxt;
  logic [15:0]      seq_nxt;
  logic [POS_W-1:0] pos_nxt;

  result_entry_t    fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  logic             in_fire, out_fire, fwd, push_two, push_any;
  logic [PTR_W-1:0] wr_ptr_p1, wr_ptr_p2, rd_ptr_p1;
  logic [LEN_W-1:0] frame_len, need_len;
  status_t          status;
  result_entry_t    payload_entry, summary_entry, first_entry;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_magic_r   <= 8'd0;
      expected_version_r <= 8'd1;
      hop_limit_r        <= 8'd15;
      payload_limit_r    <= 8'd200;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EXPECTED_MAGIC:   expected_magic_r   <= cfg_wdata;
        REG_EXPECTED_VERSION: expected_version_r <= cfg_wdata;
        REG_HOP_LIMIT:        hop_limit_r        <= cfg_wdata;
        REG_PAYLOAD_LIMIT:    payload_limit_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    magic_nxt        = magic_r;
    version_nxt      = version_r;
    type_nxt         = type_r;
    src_nxt          = src_r;
    dst_nxt          = dst_r;
    next_hop_nxt     = next_hop_r;
    hops_taken_nxt   = hops_taken_r;
    hops_allowed_nxt = hops_allowed_r;
    seq_nxt          = seq_r;
    len_nxt          = len_r;
    case (pos_r) inside
      POS_MAGIC:                    magic_nxt        = in_tdata;
      POS_VERSION:                  version_nxt      = in_tdata;
      POS_TYPE:                     type_nxt         = in_tdata;
      [POS_SRC_FIRST:POS_SRC_LAST]: src_nxt          = {src_r[23:0], in_tdata};
      [POS_DST_FIRST:POS_DST_LAST]: dst_nxt          = {dst_r[23:0], in_tdata};
      [POS_NXT_FIRST:POS_NXT_LAST]: next_hop_nxt     = {next_hop_r[23:0], in_tdata};
      POS_HOPS:                     hops_taken_nxt   = in_tdata;
      POS_MAX_HOPS:                 hops_allowed_nxt = in_tdata;
      [POS_SEQ_FIRST:POS_SEQ_LAST]: seq_nxt          = {seq_r[7:0], in_tdata};
      POS_LENGTH:                   len_nxt          = in_tdata;
      default: ;
    endcase
  end

  assign pos_nxt   = (pos_r == POS_W'(POS_MAX)) ? pos_r : pos_r + 1'b1;
  assign frame_len = LEN_W'(pos_r) + 1'b1;
  assign need_len  = LEN_W'(HEADER_BYTES) + LEN_W'(len_nxt);

  // Payload positions never touch the length byte, so the stored length applies.
  assign fwd = (pos_r >= POS_W'(HEADER_BYTES)) && (len_r <= payload_limit_r) &&
               (LEN_W'(pos_r) < LEN_W'(HEADER_BYTES) + LEN_W'(len_r));

  always_comb begin
    if (frame_len < LEN_W'(HEADER_BYTES)) begin
      status = ST_TOO_SMALL;
    end else if (magic_nxt != expected_magic_r) begin
      status = ST_BAD_MAGIC;
    end else if (version_nxt != expected_version_r) begin
      status = ST_BAD_VERSION;
    end else if ((type_nxt < TYPE_MIN) || (type_nxt > TYPE_MAX)) begin
      status = ST_BAD_TYPE;
    end else if (len_nxt > payload_limit_r) begin
      status = ST_TOO_LARGE;
    end else if (frame_len < need_len) begin
      status = ST_TOO_SMALL;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    payload_entry                   = '0;
    payload_entry.result_kind       = KIND_PAYLOAD;
    payload_entry.word.status       = ST_OK;
    payload_entry.word.payload_byte = in_tdata;

    summary_entry                        = '0;
    summary_entry.result_kind            = KIND_SUMMARY;
    summary_entry.word.status            = status;
    summary_entry.word.packet_type       = type_nxt;
    summary_entry.word.source_id         = src_nxt;
    summary_entry.word.destination_id    = dst_nxt;
    summary_entry.word.next_hop_id       = next_hop_nxt;
    summary_entry.word.hop_count         = hops_taken_nxt;
    summary_entry.word.max_hops          = (hops_allowed_nxt > hop_limit_r) ?
                                           hop_limit_r : hops_allowed_nxt;
    summary_entry.word.sequence_number   = seq_nxt;
    summary_entry.word.payload_length    = len_nxt;

    first_entry = fwd ? payload_entry : summary_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_tlast)) begin
      pos_r          <= '0;
      magic_r        <= '0;
      version_r      <= '0;
      type_r         <= '0;
      src_r          <= '0;
      dst_r          <= '0;
      next_hop_r     <= '0;
      hops_taken_r   <= '0;
      hops_allowed_r <= '0;
      seq_r          <= '0;
      len_r          <= '0;
    end else if (in_fire) begin
      pos_r          <= pos_nxt;
      magic_r        <= magic_nxt;
      version_r      <= version_nxt;
      type_r         <= type_nxt;
      src_r          <= src_nxt;
      dst_r          <= dst_nxt;
      next_hop_r     <= next_hop_nxt;
      hops_taken_r   <= hops_taken_nxt;
      hops_allowed_r <= hops_allowed_nxt;
      seq_r          <= seq_nxt;
      len_r          <= len_nxt;
    end
  end

  assign push_any  = in_fire && (fwd || in_tlast);
  assign push_two  = in_fire && fwd && in_tlast;
  assign wr_ptr_p1 = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign wr_ptr_p2 = (wr_ptr_p1 == PTR_LAST) ? '0 : wr_ptr_p1 + 1'b1;
  assign rd_ptr_p1 = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (push_any) begin
      fifo_r[wr_ptr_r] <= first_entry;
    end
    if (push_two) begin
      fifo_r[wr_ptr_p1] <= summary_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_two) begin
        wr_ptr_r <= wr_ptr_p2;
      end else if (push_any) begin
        wr_ptr_r <= wr_ptr_p1;
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_p1;
      end
      count_r <= count_r + CNT_W'(push_any) + CNT_W'(push_two) - CNT_W'(out_fire);
    end
  end

  // Room for two words is kept so that any byte can be taken.
  assign in_tready  = (count_r <= CNT_ACCEPT);
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = fifo_r[rd_ptr_r].word;
  assign out_tuser  = fifo_r[rd_ptr_r].result_kind;

endmodule
